@@ hw/rtl/grb_pkg.sv @@
// Shared constants and types of the glyph row raster blitter.
`timescale 1ns / 1ps

package grb_pkg;

	// Default geometry of one print line
	localparam int LINE_DOTS_DEF = 384;
	localparam int ROWS_DEF      = 24;
	localparam int POS_W_DEF     = $clog2(LINE_DOTS_DEF + 1);

	// Glyph row source and expanded pattern widths
	localparam int SRC_W = 16;
	localparam int PAT_W = 2 * SRC_W;

	// Request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_GLYPH = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Font selector codes
	localparam logic [7:0] FONT_DW_17  = 8'h17;
	localparam logic [7:0] FONT_DW_03  = 8'h03;
	localparam logic [7:0] FONT_DWH_06 = 8'h06;
	localparam logic [7:0] FONT_DW_0E  = 8'h0E;
	localparam logic [7:0] FONT_DH_05  = 8'h05;
	localparam logic [7:0] FONT_DH_07  = 8'h07;

	// Solid row used for underline, reset value of the underline mask
	localparam logic [SRC_W-1:0] UL_SOLID    = 16'hFFFF;
	localparam logic [7:0]       UL_MASK_RST = 8'h02;

	// Per-item control decoded at accept
	typedef struct packed {
		logic start;     // start of line: clear raster
		logic glyph_wr;  // glyph row with dots to merge into a valid row
		logic rd_ok;     // read request of an existing byte
	} prep_ctl_t;

endpackage

@@ hw/rtl/grb_if.sv @@
// Request and response channel interfaces of the glyph row raster blitter.
`timescale 1ns / 1ps

interface grb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [4:0] glyph_width;
	logic [15:0] row_bits;
	logic [4:0] row_index;
	logic       last_row;
	logic [7:0] font_code;
	logic [7:0] style_bits;
	logic [5:0] byte_index;

	modport source (
		output valid, req_type, glyph_width, row_bits, row_index, last_row,
		       font_code, style_bits, byte_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, glyph_width, row_bits, row_index, last_row,
		       font_code, style_bits, byte_index,
		output ready
	);
endinterface

interface grb_out_if #(
	parameter int POS_W = grb_pkg::POS_W_DEF
);
	logic             valid;
	logic             ready;
	logic [7:0]       data_byte;
	logic [POS_W-1:0] fill_position;
	logic             double_high;

	modport source (
		output valid, data_byte, fill_position, double_high,
		input  ready
	);
	modport sink (
		input  valid, data_byte, fill_position, double_high,
		output ready
	);
endinterface

@@ hw/rtl/grb_glyph_prep.sv @@
// Request decode: width clipping, dot pattern build and next fill position.
`timescale 1ns / 1ps

module grb_glyph_prep #(
	parameter int LINE_DOTS = grb_pkg::LINE_DOTS_DEF,
	parameter int ROWS      = grb_pkg::ROWS_DEF,
	localparam int POS_W    = $clog2(LINE_DOTS + 1)
) (
	input  logic [1:0]                    req_type,
	input  logic [4:0]                    glyph_width,
	input  logic [15:0]                   row_bits,
	input  logic [4:0]                    row_index,
	input  logic                          last_row,
	input  logic [7:0]                    font_code,
	input  logic [7:0]                    style_bits,
	input  logic [5:0]                    byte_index,
	input  logic [POS_W-1:0]              fill_pos,
	input  logic [7:0]                    ul_mask,
	output grb_pkg::prep_ctl_t            ctl,
	output logic [grb_pkg::PAT_W-1:0]     pat,
	output logic [POS_W-1:0]              fill_next,
	output logic                          tall_set
);

	localparam int ROW_BYTES = (LINE_DOTS + 7) / 8;

	logic                      dbl;
	logic                      tall;
	logic [4:0]                w_lim;
	logic [4:0]                w_clip;
	logic [POS_W-1:0]          span;
	logic [POS_W-1:0]          start_dot;
	logic                      row_ok;
	logic                      bottom_rows;
	logic                      ul;
	logic [grb_pkg::SRC_W-1:0] src;
	logic [grb_pkg::SRC_W-1:0] lo_mask;
	logic [grb_pkg::SRC_W-1:0] dots;
	logic [grb_pkg::PAT_W-1:0] dots_x2;
	logic                      glyph;

	// Font class
	assign dbl = (font_code == grb_pkg::FONT_DW_17) || (font_code == grb_pkg::FONT_DW_03) ||
		(font_code == grb_pkg::FONT_DWH_06) || (font_code == grb_pkg::FONT_DW_0E);
	assign tall = (font_code == grb_pkg::FONT_DH_05) || (font_code == grb_pkg::FONT_DWH_06) ||
		(font_code == grb_pkg::FONT_DH_07);

	// Clip width to glyph maximum, then to the free dots left of the fill position
	always_comb begin
		w_lim = (glyph_width > 5'd16) ? 5'd16 : glyph_width;
		if (dbl && (POS_W'({w_lim, 1'b0}) > fill_pos)) begin
			w_clip = 5'(fill_pos >> 1);
		end else if (!dbl && (POS_W'(w_lim) > fill_pos)) begin
			w_clip = 5'(fill_pos);
		end else begin
			w_clip = w_lim;
		end
	end

	assign span      = dbl ? POS_W'({w_clip, 1'b0}) : POS_W'(w_clip);
	assign start_dot = fill_pos - span;

	// Row range and underline
	assign row_ok      = {1'b0, row_index} < 6'(ROWS);
	assign bottom_rows = ({1'b0, row_index} + 6'd2) >= 6'(ROWS);
	assign ul          = row_ok && bottom_rows && ((style_bits & ul_mask) != 8'd0);
	assign src         = ul ? grb_pkg::UL_SOLID : row_bits;

	// Keep the low w_clip bits; bit k lands at dot fill_pos-1-k
	assign lo_mask = grb_pkg::SRC_W'((17'd1 << w_clip) - 17'd1);
	assign dots    = src & lo_mask;

	// Double width: every dot written twice
	always_comb begin
		for (int k = 0; k < grb_pkg::SRC_W; k++) begin
			dots_x2[2*k]     = dots[k];
			dots_x2[2*k + 1] = dots[k];
		end
	end

	assign pat = dbl ? dots_x2 : grb_pkg::PAT_W'(dots);

	// Control and next fill position
	assign glyph        = (req_type == grb_pkg::REQ_GLYPH);
	assign ctl.start    = (req_type == grb_pkg::REQ_START);
	assign ctl.glyph_wr = glyph && (w_clip != 5'd0) && row_ok;
	assign ctl.rd_ok    = (req_type == grb_pkg::REQ_READ) && row_ok &&
		({2'b00, byte_index} < 8'(ROW_BYTES));
	assign tall_set     = glyph && tall;

	always_comb begin
		case (req_type)
			grb_pkg::REQ_START: fill_next = POS_W'(LINE_DOTS);
			grb_pkg::REQ_GLYPH: fill_next = ((w_clip != 5'd0) && last_row) ? start_dot : fill_pos;
			default:            fill_next = fill_pos;
		endcase
	end

endmodule

@@ hw/rtl/glyph_row_raster_blitter_core.sv @@
// Top level of the glyph row raster blitter: line state, row memory and result register.
`timescale 1ns / 1ps
// The request is registered into the memory stage at transfer and into the result register
// when the memory stage advances, which waits while a held result is not yet taken.
// Throughput: one request per cycle unless a held result stalls. Each glyph row is a
// read-modify-write of a full raster row, with a same-row write forwarded to the next read.
// Reset: fill position LINE_DOTS, double-height flag 0, underline mask 2; per-row valid
// bits clear at once, so the raster reads zero with no clearing pass. Start clears them too.

module glyph_row_raster_blitter_core #(
	parameter int LINE_DOTS = grb_pkg::LINE_DOTS_DEF,
	parameter int ROWS      = grb_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	grb_in_if.sink        req,
	grb_out_if.source     rsp
);

	localparam int POS_W     = $clog2(LINE_DOTS + 1);
	localparam int ROW_BYTES = (LINE_DOTS + 7) / 8;
	localparam int ROW_BITS  = ROW_BYTES * 8;
	localparam int SH_W      = $clog2(ROW_BITS + 1);
	localparam int ROW_AW    = $clog2(ROWS);

	// Line state
	logic [7:0]       ul_mask_q;
	logic [POS_W-1:0] fill_q;
	logic             tall_q;
	logic [ROWS-1:0]  row_vld_q;

	// Decode of the incoming request
	grb_pkg::prep_ctl_t        ctl_d;
	logic [grb_pkg::PAT_W-1:0] pat_d;
	logic [POS_W-1:0]          fill_d;
	logic                      tall_set_d;
	logic                      tall_d;
	logic                      acc;

	// Memory stage
	logic                      v_s1;
	grb_pkg::prep_ctl_t        ctl_s1;
	logic [4:0]                row_s1;
	logic [5:0]                bidx_s1;
	logic [grb_pkg::PAT_W-1:0] pat_s1;
	logic [SH_W-1:0]           shamt_s1;
	logic [POS_W-1:0]          fill_s1;
	logic                      tall_s1;
	logic                      fwd_s1;
	logic                      adv_s1;

	// Row memory
	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_q;
	logic [ROW_BITS-1:0] wr_data_q;
	logic [ROW_BITS-1:0] base;
	logic [ROW_BITS-1:0] merged;
	logic [ROW_BITS-1:0] byte_sel;
	logic [ROW_AW-1:0]   row_addr_s1;
	logic                wr_now;
	logic [7:0]          data_s1;

	// Result register
	logic             out_v_q;
	logic [7:0]       data_q;
	logic [POS_W-1:0] fill_out_q;
	logic             tall_out_q;

	grb_glyph_prep #(
		.LINE_DOTS (LINE_DOTS),
		.ROWS      (ROWS)
	) u_prep (
		.req_type    (req.req_type),
		.glyph_width (req.glyph_width),
		.row_bits    (req.row_bits),
		.row_index   (req.row_index),
		.last_row    (req.last_row),
		.font_code   (req.font_code),
		.style_bits  (req.style_bits),
		.byte_index  (req.byte_index),
		.fill_pos    (fill_q),
		.ul_mask     (ul_mask_q),
		.ctl         (ctl_d),
		.pat         (pat_d),
		.fill_next   (fill_d),
		.tall_set    (tall_set_d)
	);

	// Handshake: memory stage moves on when the result register is free or drains
	assign adv_s1    = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || adv_s1;
	assign acc       = req.valid && req.ready;
	assign tall_d    = ctl_d.start ? 1'b0 : (tall_q | tall_set_d);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_mask_q <= grb_pkg::UL_MASK_RST;
		end else if (cfg_we) begin
			ul_mask_q <= cfg_wdata;
		end
	end

	// Fill position and double-height flag update at transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= POS_W'(LINE_DOTS);
			tall_q <= 1'b0;
		end else if (acc) begin
			fill_q <= fill_d;
			tall_q <= tall_d;
		end
	end

	// Memory stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Memory stage payload; forward flag marks a read that missed the write of this edge
	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1   <= ctl_d;
			row_s1   <= req.row_index;
			bidx_s1  <= req.byte_index;
			pat_s1   <= pat_d;
			shamt_s1 <= SH_W'(ROW_BITS) - SH_W'(fill_q);
			fill_s1  <= fill_d;
			tall_s1  <= tall_d;
			fwd_s1   <= wr_now && (row_s1 == req.row_index);
		end
	end

	// Merge the glyph dots into the current row contents
	assign row_addr_s1 = row_s1[ROW_AW-1:0];
	assign base        = fwd_s1 ? wr_data_q : (row_vld_q[row_addr_s1] ? rd_q : '0);
	assign merged      = base | (ROW_BITS'(pat_s1) << shamt_s1);
	assign wr_now      = adv_s1 && ctl_s1.glyph_wr;

	// Byte 0 is the leftmost, stored at the top of the row word
	assign byte_sel = base << {bidx_s1, 3'b000};
	assign data_s1  = ctl_s1.rd_ok ? byte_sel[ROW_BITS-1 -: 8] : 8'd0;

	// Row memory: read on transfer, write back on stage advance
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= mem[req.row_index[ROW_AW-1:0]];
		end
		if (wr_now) begin
			mem[row_addr_s1] <= merged;
			wr_data_q        <= merged;
		end
	end

	// Row valid bits: start clears all, a write marks its row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (adv_s1 && ctl_s1.start) begin
			row_vld_q <= '0;
		end else if (wr_now) begin
			row_vld_q[row_addr_s1] <= 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_q     <= data_s1;
			fill_out_q <= fill_s1;
			tall_out_q <= tall_s1;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.data_byte     = data_q;
	assign rsp.fill_position = fill_out_q;
	assign rsp.double_high   = tall_out_q;

	// Writes only ever target rows inside the raster
	a_wr_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_now |-> ({1'b0, row_s1} < 6'(ROWS)))
		else $error("raster write to a row outside the line");

	// Fill position never passes the right edge of the line
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= POS_W'(LINE_DOTS))
		else $error("fill position beyond line width");

	// A start leaves every row reading as zero
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && ctl_s1.start) |=> (row_vld_q == '0))
		else $error("row valid bits not cleared by start");

	// The double-height flag drops only on a start transfer
	a_tall_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tall_q) |-> $past(acc && ctl_d.start))
		else $error("double-height flag cleared without a start");

	// A forwarded row comes from a write done at the transfer edge
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && wr_now && (row_s1 == req.row_index)) |=> fwd_s1)
		else $error("missed forwarding of a same-row write");

endmodule
